// ===== rtl/pdve_pkg.sv =====
`default_nettype none

package pdve_pkg;

    // Field widths of the input and result items.
    localparam int TERM_W    = 12;
    localparam int DOC_W     = 63;
    localparam int BYTE_W    = 8;
    localparam int GROUP_W   = 7;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 8;

    // The term reduction runs four restoring steps per cycle, MOD_PASSES passes in all.
    localparam int MOD_STEPS  = 4;
    localparam int MOD_PASSES = 3;
    localparam int MOD_CW     = 33;

    // Handoff from the controller to the byte serializer.
    typedef struct packed {
        logic             load;
        logic             err;
        logic [DOC_W-1:0] delta;
    } pdve_emit_load_t;

endpackage

`default_nettype wire

// ===== rtl/pdve_ram.sv =====
`default_nettype none

module pdve_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pdve_term_mod.sv =====
`default_nettype none

module pdve_term_mod #(
    parameter int TERM_COUNT = 4096
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [pdve_pkg::TERM_W-1:0]      term_index,
    output logic                                  done,
    output logic      [$clog2(TERM_COUNT)-1:0]    addr
);

    localparam int AW = $clog2(TERM_COUNT);
    localparam int CW = pdve_pkg::MOD_CW;

    logic [pdve_pkg::TERM_W-1:0] rem_reg, rem_next;
    logic [1:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    // Four restoring-division steps against shifted copies of the term count.
    always_comb begin
        logic [CW-1:0] rem_v;
        logic [CW-1:0] cmp;
        logic [3:0]    sh;
        rem_v = CW'(rem_reg);
        for (int j = 0; j < pdve_pkg::MOD_STEPS; j++) begin
            sh  = 4'(pdve_pkg::TERM_W - 1 - pdve_pkg::MOD_STEPS * int'(cnt_reg) - j);
            cmp = CW'(TERM_COUNT) << sh;
            if (rem_v >= cmp) begin
                rem_v = rem_v - cmp;
            end
        end
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = term_index;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = pdve_pkg::TERM_W'(rem_v);
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'(pdve_pkg::MOD_PASSES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // The remainder is payload and needs no reset.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign addr = AW'(rem_reg);

endmodule

`default_nettype wire

// ===== rtl/pdve_emit.sv =====
`default_nettype none

module pdve_emit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire pdve_pkg::pdve_emit_load_t           load,
    output logic                                     busy,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [pdve_pkg::M_TDATA_W-1:0]      m_tdata,  // [7:0] code_byte
    output logic                                     m_tlast,
    output logic      [0:0]                          m_tuser   // [0] order_error
);

    localparam int GW = pdve_pkg::GROUP_W;

    logic                           active_reg, active_next;
    logic                           err_reg, err_next;
    logic [pdve_pkg::DOC_W-1:0]     shift_reg, shift_next;
    logic                           out_valid_reg, out_valid_next;
    logic [pdve_pkg::BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                           out_last_reg, out_last_next;
    logic                           out_err_reg, out_err_next;
    logic                           fire;
    logic                           more;
    logic [pdve_pkg::DOC_W-1:0]     rest;

    // While a run is active, a byte moves into the output register whenever it is empty or being drained.
    assign fire = active_reg && (!out_valid_reg || m_tready);
    assign rest = shift_reg >> GW;
    assign more = (rest != '0);

    always_comb begin
        active_next    = active_reg;
        err_next       = err_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (load.load) begin
            active_next = 1'b1;
            err_next    = load.err;
            shift_next  = load.delta;
        end else if (fire) begin
            out_valid_next = 1'b1;
            out_err_next   = err_reg;
            if (err_reg) begin
                out_byte_next = '0;
                out_last_next = 1'b1;
                active_next   = 1'b0;
            end else begin
                out_byte_next = {more, shift_reg[GW-1:0]};
                out_last_next = !more;
                shift_next    = rest;
                active_next   = more;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        err_reg      <= err_next;
        shift_reg    <= shift_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign busy     = active_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

`default_nettype wire

// ===== rtl/posting_delta_varint_encoder_core.sv =====
// Channel   Dir  tdata (low bit up)                        tlast         tuser
// s_        in   term_index[11:0], doc_number[74:12], pad   -             -
// m_        out  code_byte[7:0]                             last_of_run   order_error
//
// One item is handled at a time: the next input is accepted only once the last code
// byte of its run has moved into the output register; an order error gives one zero byte.
// Steps in order: the term index is reduced modulo TERM_COUNT, the table is read through
// a registered port, then the compare and write-back are done and the serializer loaded.
// After reset the table is cleared one entry a cycle, all TERM_COUNT entries, with s_tready low.
// A stalled m_ side holds the byte in the output register and pauses the run.
`default_nettype none

module posting_delta_varint_encoder_core #(
    parameter int TERM_COUNT = 4096
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [pdve_pkg::S_TDATA_W-1:0]     s_tdata,  // [11:0] term_index, [74:12] doc_number
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [pdve_pkg::M_TDATA_W-1:0]     m_tdata,  // [7:0] code_byte
    output logic                                    m_tlast,
    output logic      [0:0]                         m_tuser   // [0] order_error
);

    localparam int AW = $clog2(TERM_COUNT);
    localparam int DW = pdve_pkg::DOC_W;
    localparam int TW = pdve_pkg::TERM_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [DW-1:0]           doc_reg;
    logic                    accept;
    logic                    mod_done;
    logic [AW-1:0]           mod_addr;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DW-1:0]           ram_wdata;
    logic                    ram_re;
    logic [DW-1:0]           ram_rdata;
    logic [DW:0]             diff;
    logic                    order_err;
    logic                    emit_busy;
    pdve_pkg::pdve_emit_load_t emit_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    pdve_term_mod #(
        .TERM_COUNT (TERM_COUNT)
    ) u_term_mod (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .term_index (s_tdata[TW-1:0]),
        .done       (mod_done),
        .addr       (mod_addr)
    );

    pdve_ram #(
        .WIDTH (DW),
        .DEPTH (TERM_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (mod_addr),
        .rd_data (ram_rdata)
    );

    // The new number must be strictly above the stored one.
    assign diff      = {1'b0, doc_reg} - {1'b0, ram_rdata};
    assign order_err = diff[DW] || (diff[DW-1:0] == '0);

    // The clearing pass and the write-back share the single write port.
    always_comb begin
        ram_re    = (state_reg == ST_REDUCE) && mod_done;
        ram_we    = 1'b0;
        ram_waddr = mod_addr;
        ram_wdata = doc_reg;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_CHECK) begin
            ram_we = !order_err;
        end
    end

    assign emit_load.load  = (state_reg == ST_CHECK);
    assign emit_load.err   = order_err;
    assign emit_load.delta = diff[DW-1:0];

    // Sequencer: clear the table after reset, then for one item: reduce, read, compare and write back, serialize.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(TERM_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mod_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!emit_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // The document number is held for the compare and the write-back.
    always_ff @(posedge aclk) begin
        if (accept) begin
            doc_reg <= s_tdata[TW +: DW];
        end
    end

    pdve_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (emit_load),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/pdve_checker.sv =====
`default_nettype none

module pdve_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [pdve_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast,
    input wire logic [0:0]                     m_tuser
);

    // A stalled result transaction keeps its byte and flags.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // An order error is a single zero byte that closes its run.
    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("malformed order error result");

    // The continuation bit and the end-of-run flag are complementary on code bytes.
    a_more_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[7] == !m_tlast))
        else $error("continuation bit disagrees with tlast");

    // Items are handled one at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind posting_delta_varint_encoder_core pdve_checker u_pdve_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
